// ===== hw/rtl/rbps_pkg.sv =====
`timescale 1ns / 1ps

package rbps_pkg;

  localparam int POOL_DEPTH = 64;
  localparam int PTR_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

  localparam logic [7:0] ROLL_LIMIT = 8'd252;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_BYTE   = 2'd1,
    OP_WORD   = 2'd2,
    OP_ROLL   = 2'd3
  } op_t;

  // die face 1..6 from a byte: quotient by reciprocal 171/1024, exact below 256
  function automatic logic [2:0] roll_face(input logic [7:0] b);
    logic [15:0] p;
    logic [5:0]  q;
    logic [7:0]  q6;
    logic [7:0]  r;
    p  = 16'(b) * 16'd171;
    q  = p[15:10];
    q6 = {q, 2'b00} + {1'b0, q, 1'b0};
    r  = b - q6;
    return r[2:0] + 3'd1;
  endfunction

endpackage

// ===== hw/rtl/rbps_pool_ram.sv =====
`timescale 1ns / 1ps

module rbps_pool_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/random_byte_pool_server.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall   | opcode, sample_byte, requester
// out     | output    | out_valid/out_stall | reply_valid, reply_dest, reply_value,
//         |           |                     | request_error
// An event reading no pool entry runs S_IDLE, S_TRY, S_FIN; a byte or roll adds S_READ
// and S_WAIT; a word reads 4 bytes in S_READ, one per cycle from the single-port pool.
// rst_n is synchronous; it empties the pool and drops any pending request.
// A finished beat waits in the output register; the next event is taken meanwhile.

module random_byte_pool_server
  import rbps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_sample_byte,
  input  logic [7:0]  in_requester,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_reply_valid,
  output logic [7:0]  out_reply_dest,
  output logic [31:0] out_reply_value,
  output logic        out_request_error
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRY,
    S_READ,
    S_WAIT,
    S_FIN
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic             pend_r;
  logic [7:0]       pend_who_r;
  op_t              pend_kind_r;
  logic             err_r;
  logic             srv_r;
  logic [PTR_W-1:0] addr_r;
  logic [1:0]       left_r;
  logic             rd_pend_r;
  logic [31:0]      word_r;
  logic             out_valid_r;
  logic             out_rv_r;
  logic [7:0]       out_dest_r;
  logic [31:0]      out_value_r;
  logic             out_err_r;

  logic             ram_we;
  logic [PTR_W-1:0] ram_addr;
  logic [7:0]       ram_rdata;
  logic             in_fire;
  logic             out_free;
  logic             can_serve;
  logic [CNT_W-1:0] need;
  logic             reply;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign need      = (pend_kind_r == OP_WORD) ? CNT_W'(4) : CNT_W'(1);
  assign can_serve = pend_r && (count_r >= need);
  assign reply     = srv_r && ((pend_kind_r != OP_ROLL) || (word_r[7:0] < ROLL_LIMIT));

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = addr_r;
    if (state_r == S_IDLE) begin
      ram_addr = count_r[PTR_W-1:0];
      ram_we   = in_fire && (op_t'(in_opcode) == OP_SAMPLE) &&
                 (count_r < CNT_W'(POOL_DEPTH));
    end
  end

  rbps_pool_ram #(
    .DEPTH (POOL_DEPTH),
    .WIDTH (8)
  ) u_pool (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_sample_byte),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    rd_pend_r <= (state_r == S_READ);
    if (rd_pend_r) begin
      word_r <= {word_r[23:0], ram_rdata};
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      pend_who_r  <= '0;
      pend_kind_r <= OP_SAMPLE;
      err_r       <= 1'b0;
      srv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            err_r <= 1'b0;
            if (op_t'(in_opcode) == OP_SAMPLE) begin
              if (count_r < CNT_W'(POOL_DEPTH)) begin
                count_r <= count_r + CNT_W'(1);
              end
            end else if (pend_r) begin
              err_r <= 1'b1;
            end else begin
              pend_r      <= 1'b1;
              pend_who_r  <= in_requester;
              pend_kind_r <= op_t'(in_opcode);
            end
            state_r <= S_TRY;
          end
        end
        S_TRY: begin
          srv_r <= can_serve;
          if (can_serve) begin
            addr_r  <= PTR_W'(count_r - need);
            left_r  <= 2'(need - CNT_W'(1));
            count_r <= count_r - need;
            state_r <= S_READ;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_READ: begin
          addr_r <= addr_r + PTR_W'(1);
          if (left_r == 2'd0) begin
            state_r <= S_WAIT;
          end else begin
            left_r <= left_r - 2'd1;
          end
        end
        S_WAIT: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_rv_r    <= reply;
            out_dest_r  <= reply ? pend_who_r : 8'd0;
            out_err_r   <= err_r;
            if (!reply) begin
              out_value_r <= '0;
            end else if (pend_kind_r == OP_WORD) begin
              out_value_r <= word_r;
            end else if (pend_kind_r == OP_ROLL) begin
              out_value_r <= {29'd0, roll_face(word_r[7:0])};
            end else begin
              out_value_r <= {24'd0, word_r[7:0]};
            end
            if (reply) begin
              pend_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_reply_valid   = out_rv_r;
  assign out_reply_dest    = out_dest_r;
  assign out_reply_value   = out_value_r;
  assign out_request_error = out_err_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(POOL_DEPTH))
    else $error("pool count beyond depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> count_r <= $past(count_r) + CNT_W'(1))
    else $error("pool count grew by more than one");

  a_reply_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free && reply) |=> !pend_r && out_valid_r && out_rv_r)
    else $error("reply left request pending");

  a_serve_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ || state_r == S_WAIT) |-> pend_r && srv_r)
    else $error("pool read without pending request");
`endif

endmodule

// ===== bench/tb_random_byte_pool_server.sv =====
`timescale 1ns / 1ps

module tb_random_byte_pool_server
  import rbps_pkg::*;
;

  localparam int CYCLE_LIMIT = 250000;
  localparam int IDLE_PCT    = 38;
  localparam int TAIL_CYCLES = 16;

  typedef struct packed {
    logic        reply_valid;
    logic [7:0]  reply_dest;
    logic [31:0] reply_value;
    logic        request_error;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = OP_SAMPLE;
  logic [7:0]  in_sample_byte = 8'h00;
  logic [7:0]  in_requester = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_reply_valid;
  logic [7:0]  out_reply_dest;
  logic [31:0] out_reply_value;
  logic        out_request_error;

  logic [7:0]   pool_model [POOL_DEPTH];
  int           pool_fill;
  logic         req_waiting;
  logic [7:0]   req_owner;
  op_t          req_kind;

  reply_t       pending_replies[$];
  reply_t       oldest_reply;
  int           mismatches = 0;
  int           cycle_cnt = 0;
  int           hold_left = 0;
  bit           idle_on = 1'b1;

  random_byte_pool_server i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_sample_byte    (in_sample_byte),
    .in_requester      (in_requester),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_reply_valid   (out_reply_valid),
    .out_reply_dest    (out_reply_dest),
    .out_reply_value   (out_reply_value),
    .out_request_error (out_request_error)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("random_byte_pool_server test failed");
      $finish;
    end
  end

  function automatic reply_t serve_event(op_t op, logic [7:0] sample, logic [7:0] who);
    reply_t r;
    logic [7:0] b;
    r = '0;
    if (op == OP_SAMPLE) begin
      if (pool_fill < POOL_DEPTH) begin
        pool_model[pool_fill] = sample;
        pool_fill++;
      end
    end else if (req_waiting) begin
      r.request_error = 1'b1;
    end else begin
      req_waiting = 1'b1;
      req_owner   = who;
      req_kind    = op;
    end
    if (req_waiting && pool_fill > 0) begin
      case (req_kind)
        OP_BYTE: begin
          pool_fill--;
          r.reply_valid = 1'b1;
          r.reply_value = {24'h0, pool_model[pool_fill]};
        end
        OP_WORD: begin
          if (pool_fill >= 4) begin
            pool_fill -= 4;
            r.reply_valid = 1'b1;
            r.reply_value = {pool_model[pool_fill], pool_model[pool_fill + 1],
                             pool_model[pool_fill + 2], pool_model[pool_fill + 3]};
          end
        end
        OP_ROLL: begin
          pool_fill--;
          b = pool_model[pool_fill];
          if (b < ROLL_LIMIT) begin
            r.reply_valid = 1'b1;
            r.reply_value = 32'(b) % 32'd6 + 32'd1;
          end
        end
        default: ;
      endcase
    end
    if (r.reply_valid) begin
      r.reply_dest = req_owner;
      req_waiting  = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t ns mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  task automatic idle_gap();
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_valid       = 1'b0;
      in_opcode      = 2'($urandom_range(3));
      in_sample_byte = 8'($urandom_range(255));
      in_requester   = 8'($urandom_range(255));
    end
  endtask

  task automatic send_event(input op_t op, input logic [7:0] sample, input logic [7:0] who);
    idle_gap();
    @(negedge clk);
    in_valid       = 1'b1;
    in_opcode      = op;
    in_sample_byte = sample;
    in_requester   = who;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_replies.push_back(serve_event(op, sample, who));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected beat", out_reply_value, 32'h0);
      end else begin
        oldest_reply = pending_replies.pop_front();
        if (out_reply_valid !== oldest_reply.reply_valid)
          report_mismatch("reply_valid", 32'(out_reply_valid), 32'(oldest_reply.reply_valid));
        if (out_reply_dest !== oldest_reply.reply_dest)
          report_mismatch("reply_dest", 32'(out_reply_dest), 32'(oldest_reply.reply_dest));
        if (out_reply_value !== oldest_reply.reply_value)
          report_mismatch("reply_value", out_reply_value, oldest_reply.reply_value);
        if (out_request_error !== oldest_reply.request_error)
          report_mismatch("request_error", 32'(out_request_error),
                          32'(oldest_reply.request_error));
      end
    end
  end

  function automatic op_t pick_op(int sample_pct);
    if ($urandom_range(99) < sample_pct) return OP_SAMPLE;
    if (req_waiting && $urandom_range(99) < 75) return OP_SAMPLE;
    return op_t'($urandom_range(3, 1));
  endfunction

  function automatic logic [7:0] pick_sample();
    if ($urandom_range(99) < 15) return 8'($urandom_range(255, 252));
    return 8'($urandom_range(255));
  endfunction

  task automatic test_directed();
    send_event(OP_BYTE,   8'h00, 8'h00);
    send_event(OP_SAMPLE, 8'h00, 8'hFF);
    send_event(OP_WORD,   8'hFF, 8'hFF);
    send_event(OP_SAMPLE, 8'hFF, 8'h00);
    send_event(OP_SAMPLE, 8'h00, 8'h00);
    send_event(OP_SAMPLE, 8'hA5, 8'h00);
    send_event(OP_SAMPLE, 8'h5A, 8'h00);
    send_event(OP_ROLL,   8'h00, 8'h5A);
    send_event(OP_BYTE,   8'h00, 8'h11);
    send_event(OP_SAMPLE, 8'd252, 8'h00);
    send_event(OP_SAMPLE, 8'd255, 8'h00);
    send_event(OP_SAMPLE, 8'd251, 8'h00);
    send_event(OP_SAMPLE, 8'd10, 8'h00);
    send_event(OP_SAMPLE, 8'd253, 8'h00);
    send_event(OP_ROLL,   8'h00, 8'h80);
    send_event(OP_WORD,   8'h00, 8'h01);
    send_event(OP_SAMPLE, 8'h00, 8'h00);
    send_event(OP_ROLL,   8'h00, 8'hFE);
    send_event(OP_SAMPLE, 8'h01, 8'h00);
    send_event(OP_SAMPLE, 8'h02, 8'h00);
    send_event(OP_SAMPLE, 8'h03, 8'h00);
    send_event(OP_WORD,   8'h00, 8'h77);
    send_event(OP_SAMPLE, 8'h04, 8'h00);
  endtask

  task automatic test_full_pool();
    for (int i = 0; i < POOL_DEPTH + 6; i++)
      send_event(OP_SAMPLE, pick_sample(), 8'($urandom_range(255)));
    for (int i = 0; i < POOL_DEPTH / 4; i++)
      send_event(OP_WORD, 8'($urandom_range(255)), 8'($urandom_range(255)));
    send_event(OP_BYTE, 8'h00, 8'($urandom_range(255)));
    send_event(OP_SAMPLE, pick_sample(), 8'h00);
  endtask

  task automatic test_random_mix(input int n);
    int seg_left;
    int sample_pct;
    seg_left = 0;
    sample_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(80, 20);
        case ($urandom_range(2))
          0:       sample_pct = 30;
          1:       sample_pct = 55;
          default: sample_pct = 92;
        endcase
      end
      seg_left--;
      send_event(pick_op(sample_pct), pick_sample(), 8'($urandom_range(255)));
    end
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    test_random_mix(300);
    idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    @(negedge clk);
    hold_left = 400;
    test_random_mix(60);
  endtask

  task automatic test_pause_until_drained();
    test_random_mix(30);
    wait_drained();
    test_random_mix(30);
  endtask

  initial begin
    for (int i = 0; i < POOL_DEPTH; i++) pool_model[i] = 8'h00;
    pool_fill   = 0;
    req_waiting = 1'b0;
    req_owner   = 8'h00;
    req_kind    = OP_SAMPLE;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_full_pool();
    test_no_idle();
    test_backpressure();
    test_pause_until_drained();
    test_random_mix(1300);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0)
      report_mismatch("beats left over", 32'(pending_replies.size()), 32'h0);
    if (mismatches == 0) begin
      $display("random_byte_pool_server test passed");
    end else begin
      $display("random_byte_pool_server test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rbps_pkg.sv
hw/rtl/rbps_pool_ram.sv
hw/rtl/random_byte_pool_server.sv
bench/tb_random_byte_pool_server.sv
